// ===== hdl/mqrr_pkg.sv =====
// shared types, codes and defaults of the round-robin multi-queue fifo
`default_nettype none

package mqrr_pkg;

  // payload widths fixed by the channel definition
  localparam int QIDX_W   = 2;
  localparam int EVENT_W  = 64;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // configuration registers
  localparam int ACTQ_W = 3;
  localparam int CAP_W  = 5;
  localparam logic REG_ACTIVE_QUEUES  = 1'b0;
  localparam logic REG_QUEUE_CAPACITY = 1'b1;
  localparam logic [ACTQ_W-1:0] ACTQ_RESET = 3'd4;
  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // parameter defaults
  localparam int DEF_NUM_QUEUES  = 4;
  localparam int DEF_DEPTH       = 16;
  localparam int DEF_EVENT_WIDTH = 64;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;

  typedef struct packed {
    logic              is_recv;
    logic              unconn;
    logic              drop;
    logic [QIDX_W-1:0] queue_index;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/mqrr_if.sv =====
// request and result channel interfaces of the round-robin multi-queue fifo
`default_nettype none

interface mqrr_in_if
  import mqrr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [QIDX_W-1:0] queue_index;
  logic [EVENT_W-1:0] event_data;
  logic              drop_full;

  modport source (output valid, command, queue_index, event_data, drop_full, input ready);
  modport sink   (input valid, command, queue_index, event_data, drop_full, output ready);
endinterface

interface mqrr_out_if
  import mqrr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [EVENT_W-1:0]  event_out;
  logic [QIDX_W-1:0]   source_queue;

  modport source (output valid, status, event_out, source_queue, input ready);
  modport sink   (input valid, status, event_out, source_queue, output ready);
endinterface

`default_nettype wire

// ===== hdl/mqrr_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
`default_nettype none

module mqrr_front
  import mqrr_pkg::*;
#(
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
  parameter int EVENT_WIDTH = DEF_EVENT_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  mqrr_in_if.sink                                     in_ch,
  input  wire logic [$clog2(NUM_QUEUES+1)-1:0]        act_eff,
  output logic                                        cmd_valid,
  output cmd_ctrl_t                                   cmd_ctrl,
  output logic [EVENT_WIDTH-1:0]                      cmd_data,
  input  wire logic                                   cmd_pop
);

  localparam int CQ_PW = $clog2(CQ_DEPTH);
  localparam int CQ_CW = $clog2(CQ_DEPTH+1);

  cmd_ctrl_t              ctrl_q_r [CQ_DEPTH];
  logic [EVENT_WIDTH-1:0] data_q_r [CQ_DEPTH];
  logic [CQ_PW-1:0]       wp_r, wp_nxt;
  logic [CQ_PW-1:0]       rp_r, rp_nxt;
  logic [CQ_CW-1:0]       fill_r, fill_nxt;
  logic                   push;
  cmd_ctrl_t              new_ctrl;

  assign in_ch.ready = (fill_r != CQ_CW'(CQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  // a send to a queue beyond the connected ones behaves as a full queue
  always_comb begin
    new_ctrl.is_recv     = (in_ch.command == CMD_RECV);
    new_ctrl.unconn      = (32'(in_ch.queue_index) >= 32'(act_eff));
    new_ctrl.drop        = in_ch.drop_full;
    new_ctrl.queue_index = in_ch.queue_index;
  end

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    if (push) begin
      wp_nxt = (wp_r == CQ_PW'(CQ_DEPTH-1)) ? '0 : wp_r + CQ_PW'(1);
    end
    if (cmd_pop) begin
      rp_nxt = (rp_r == CQ_PW'(CQ_DEPTH-1)) ? '0 : rp_r + CQ_PW'(1);
    end
    if (push && !cmd_pop) begin
      fill_nxt = fill_r + CQ_CW'(1);
    end else if (!push && cmd_pop) begin
      fill_nxt = fill_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q_r[wp_r] <= new_ctrl;
      data_q_r[wp_r] <= in_ch.event_data[EVENT_WIDTH-1:0];
    end
  end

  assign cmd_valid = (fill_r != '0);
  assign cmd_ctrl  = ctrl_q_r[rp_r];
  assign cmd_data  = data_q_r[rp_r];

endmodule

`default_nettype wire

// ===== hdl/mqrr_back.sv =====
// back end: queue state, event store, round-robin search and result register
`default_nettype none

module mqrr_back
  import mqrr_pkg::*;
#(
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
  parameter int DEPTH       = DEF_DEPTH,
  parameter int EVENT_WIDTH = DEF_EVENT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  input  wire cmd_ctrl_t                         cmd_ctrl,
  input  wire logic [EVENT_WIDTH-1:0]            cmd_data,
  output logic                                   cmd_pop,
  input  wire logic [$clog2(NUM_QUEUES+1)-1:0]   act_eff,
  input  wire logic [$clog2(DEPTH+1)-1:0]        cap_eff,
  mqrr_out_if.source                             out_ch
);

  localparam int QIW  = $clog2(NUM_QUEUES);
  localparam int QCW  = $clog2(NUM_QUEUES+1);
  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH+1);
  localparam int AW   = $clog2(NUM_QUEUES*DEPTH);
  localparam int SUMW = CW + 1;

  localparam logic [1:0] S_EXEC   = 2'd0;
  localparam logic [1:0] S_REDUCE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;

  logic [EVENT_WIDTH-1:0] mem [NUM_QUEUES*DEPTH];
  logic [EVENT_WIDTH-1:0] rd_data_r;
  logic [QIW-1:0]         rd_src_r;

  logic [PW-1:0]  rptr_r [NUM_QUEUES];
  logic [PW-1:0]  rptr_nxt [NUM_QUEUES];
  logic [CW-1:0]  cnt_r [NUM_QUEUES];
  logic [CW-1:0]  cnt_nxt [NUM_QUEUES];
  logic [QIW-1:0] ls_r, ls_nxt;
  logic           has_ls_r, has_ls_nxt;
  logic [1:0]     state_r, state_nxt;
  logic [QCW-1:0] s_r, s_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [EVENT_W-1:0]  out_event_r, out_event_nxt;
  logic [QIDX_W-1:0]   out_src_r, out_src_nxt;

  logic                  out_free;
  logic [QIW-1:0]        q_int;
  logic [QCW-1:0]        ls_inc;
  logic                  need_reduce;
  logic [QCW-1:0]        start_direct;
  logic [QCW-1:0]        start_sel;
  logic [NUM_QUEUES-1:0] mask;
  logic [NUM_QUEUES-1:0] hi_mask;
  logic [QIW-1:0]        sel_lo, sel_hi, sel;
  logic                  found;
  logic [QIW-1:0]        tq;
  logic [CW-1:0]         cnt_t;
  logic [PW-1:0]         rptr_t;
  logic                  full;
  logic [SUMW-1:0]       sum;
  logic [PW-1:0]         wslot;
  logic [PW-1:0]         rp_next;
  logic [AW-1:0]         addr_w, addr_r;
  logic                  do_send, recv_exec, go_reduce, reduce_done, do_search;
  logic                  do_hit, mem_we;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_int    = QIW'(32'(cmd_ctrl.queue_index));

  // search start: just past the last served queue, folded into the connected range
  assign ls_inc       = QCW'(32'(ls_r) + 1);
  assign need_reduce  = has_ls_r && (ls_inc > act_eff);
  assign start_direct = (!has_ls_r || ls_inc == act_eff) ? '0 : ls_inc;
  assign start_sel    = (state_r == S_REDUCE) ? s_r : start_direct;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      mask[i]    = (cnt_r[i] != '0) && (i < 32'(act_eff));
      hi_mask[i] = mask[i] && (i >= 32'(start_sel));
    end
  end

  // first non-empty queue at or after the start, else wrap to the lowest one
  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = NUM_QUEUES-1; i >= 0; i--) begin
      if (mask[i]) begin
        sel_lo = QIW'(i);
      end
      if (hi_mask[i]) begin
        sel_hi = QIW'(i);
      end
    end
    sel   = (|hi_mask) ? sel_hi : sel_lo;
    found = |mask;
  end

  assign tq     = cmd_ctrl.is_recv ? sel : q_int;
  assign cnt_t  = cnt_r[tq];
  assign rptr_t = rptr_r[tq];
  assign full   = cmd_ctrl.unconn || (cnt_t >= cap_eff);

  // ring slots wrap at the physical depth
  assign sum     = SUMW'(rptr_t) + SUMW'(cnt_t);
  assign wslot   = (sum >= SUMW'(DEPTH)) ? PW'(sum - SUMW'(DEPTH)) : PW'(sum);
  assign rp_next = (rptr_t == PW'(DEPTH-1)) ? '0 : rptr_t + PW'(1);
  assign addr_w  = AW'(32'(tq) * DEPTH + 32'(wslot));
  assign addr_r  = AW'(32'(tq) * DEPTH + 32'(rptr_t));

  assign do_send     = (state_r == S_EXEC) && cmd_valid && !cmd_ctrl.is_recv && out_free;
  assign recv_exec   = (state_r == S_EXEC) && cmd_valid && cmd_ctrl.is_recv && out_free;
  assign go_reduce   = recv_exec && need_reduce;
  assign reduce_done = (state_r == S_REDUCE) && (s_r < act_eff);
  assign do_search   = (recv_exec && !need_reduce) || (reduce_done && out_free);
  assign do_hit      = do_search && found;
  assign mem_we      = do_send && !full;
  assign cmd_pop     = do_send || do_search;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      rptr_nxt[i] = rptr_r[i];
    end
    ls_nxt     = ls_r;
    has_ls_nxt = has_ls_r;
    if (mem_we) begin
      cnt_nxt[tq] = cnt_t + CW'(1);
    end
    if (do_hit) begin
      cnt_nxt[tq]  = cnt_t - CW'(1);
      rptr_nxt[tq] = rp_next;
      ls_nxt       = tq;
      has_ls_nxt   = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    case (state_r)
      S_EXEC: begin
        if (go_reduce) begin
          state_nxt = S_REDUCE;
          s_nxt     = ls_inc - act_eff;
        end else if (do_hit) begin
          state_nxt = S_READ;
        end
      end
      S_REDUCE: begin
        if (!reduce_done) begin
          s_nxt = s_r - act_eff;
        end else if (do_search) begin
          state_nxt = do_hit ? S_READ : S_EXEC;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_event_nxt  = out_event_r;
    out_src_nxt    = out_src_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_send) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = !full ? ST_DONE : (cmd_ctrl.drop ? ST_DROPPED : ST_REFUSED);
      out_event_nxt  = '0;
      out_src_nxt    = '0;
    end else if (do_search && !found) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_EMPTY;
      out_event_nxt  = '0;
      out_src_nxt    = '0;
    end else if (state_r == S_READ && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_event_nxt  = EVENT_W'(rd_data_r);
      out_src_nxt    = QIDX_W'(32'(rd_src_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= '0;
        rptr_r[i] <= '0;
      end
      ls_r        <= '0;
      has_ls_r    <= 1'b0;
      state_r     <= S_EXEC;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        rptr_r[i] <= rptr_nxt[i];
      end
      ls_r        <= ls_nxt;
      has_ls_r    <= has_ls_nxt;
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_event_r  <= out_event_nxt;
    out_src_r    <= out_src_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_w] <= cmd_data;
    end
    if (do_hit) begin
      rd_data_r <= mem[addr_r];
      rd_src_r  <= tq;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.event_out    = out_event_r;
  assign out_ch.source_queue = out_src_r;

endmodule

`default_nettype wire

// ===== hdl/multi_queue_round_robin_fifo.sv =====
// top level of the round-robin multi-queue fifo: register port, front and back ends
`default_nettype none

// NUM_QUEUES ring-buffer queues share one event store and one receiver. Each request
// gives exactly one result. Requests enter a two-entry command queue, so the input
// keeps accepting while a result waits on the output, until that queue is full. A
// send is executed in the S_EXEC state of the back end; a receive runs a round-robin
// search over the per-queue counts and, on a hit, a registered read of the event
// store. After active_queues is lowered below the queue served last, the next receive
// first subtracts active_queues from its search start in the S_REDUCE state until
// that start is back in range. The store has no clearing pass after reset. Registers
// sit at byte addresses 0 (active_queues) and 4 (queue_capacity); the user must write
// them only while no request is in flight, since the block does not enforce this.
module multi_queue_round_robin_fifo
  import mqrr_pkg::*;
#(
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
  parameter int DEPTH       = DEF_DEPTH,
  parameter int EVENT_WIDTH = DEF_EVENT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mqrr_in_if.sink                in_ch,
  mqrr_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int QCW = $clog2(NUM_QUEUES+1);
  localparam int CW  = $clog2(DEPTH+1);

  logic [ACTQ_W-1:0]      actq_r;
  logic [CAP_W-1:0]       cap_r;
  logic [QCW-1:0]         act_eff;
  logic [CW-1:0]          cap_eff;
  logic                   cfg_wr;
  logic                   reg_sel;
  logic                   cmd_valid;
  cmd_ctrl_t              cmd_ctrl;
  logic [EVENT_WIDTH-1:0] cmd_data;
  logic                   cmd_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      actq_r <= ACTQ_RESET;
      cap_r  <= CAP_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_ACTIVE_QUEUES) begin
        actq_r <= pwdata[ACTQ_W-1:0];
      end else begin
        cap_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_ACTIVE_QUEUES) ? CFG_DW'(actq_r) : CFG_DW'(cap_r);

  // registers are clamped to their usable range where they are used
  always_comb begin
    if (actq_r == '0) begin
      act_eff = QCW'(1);
    end else if (32'(actq_r) > NUM_QUEUES) begin
      act_eff = QCW'(NUM_QUEUES);
    end else begin
      act_eff = QCW'(actq_r);
    end
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  mqrr_front #(
    .NUM_QUEUES  (NUM_QUEUES),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .act_eff   (act_eff),
    .cmd_valid (cmd_valid),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  mqrr_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .DEPTH       (DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .act_eff   (act_eff),
    .cap_eff   (cap_eff),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd_valid)
    else $error("accepted request missing from command queue");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_DONE) |->
    (out_ch.event_out == '0 && out_ch.source_queue == '0))
    else $error("failed request carries event payload");
`endif

endmodule

`default_nettype wire

// ===== tb/multi_queue_round_robin_fifo_test.sv =====
// self-checking testbench of the round-robin multi-queue fifo with its own queue predictor
`default_nettype none

module multi_queue_round_robin_fifo_test;
  import mqrr_pkg::*;

  localparam int NQ          = DEF_NUM_QUEUES;
  localparam int SLOTS       = DEF_DEPTH;
  localparam int GAP_MAX     = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int LATENCY_PAD = 12;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int BURST_ITEMS = 60;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EVENT_W-1:0]  event_word;
    logic [QIDX_W-1:0]   src_queue;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  mqrr_in_if  in_ch ();
  mqrr_out_if out_ch ();

  multi_queue_round_robin_fifo DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted queue contents and round-robin state
  logic [EVENT_W-1:0] event_mem [NQ][SLOTS];
  int unsigned        head_ptr [NQ];
  int unsigned        fill [NQ];
  int unsigned        last_queue;
  bit                 served_any;
  logic [ACTQ_W-1:0]  active_reg;
  logic [CAP_W-1:0]   cap_reg;

  outcome_t    awaited [$];
  outcome_t    oldest;
  int          mismatch_count;
  int          status_tally [4];
  int          send_total;
  int          recv_total;
  int          settings_total;
  bit          gaps_on;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [EVENT_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic outcome_t predict_outcome(input logic cmd, input logic [QIDX_W-1:0] q,
                                               input logic [EVENT_W-1:0] data,
                                               input logic drop);
    int unsigned act;
    int unsigned cap;
    int unsigned start;
    int unsigned idx;
    bit          found;
    outcome_t    r;
    act = (active_reg < 1) ? 1 : ((active_reg > NQ) ? NQ : active_reg);
    cap = (cap_reg < 1) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
    r = '0;
    if (cmd == CMD_SEND) begin
      // unconnected queues look full
      if (q >= act || fill[q] >= cap) begin
        r.status = drop ? ST_DROPPED : ST_REFUSED;
      end else begin
        event_mem[q][(head_ptr[q] + fill[q]) % SLOTS] = data;
        fill[q]++;
        r.status = ST_DONE;
      end
    end else begin
      start = served_any ? (last_queue + 1) % act : 0;
      found = 1'b0;
      r.status = ST_EMPTY;
      for (int k = 0; k < act; k++) begin
        idx = (start + k) % act;
        if (!found && fill[idx] != 0) begin
          found = 1'b1;
          r.status = ST_DONE;
          r.event_word = event_mem[idx][head_ptr[idx]];
          r.src_queue = QIDX_W'(idx);
          head_ptr[idx] = (head_ptr[idx] + 1) % SLOTS;
          fill[idx]--;
          last_queue = idx;
          served_any = 1'b1;
        end
      end
    end
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic issue_request(input logic cmd, input logic [QIDX_W-1:0] q,
                               input logic [EVENT_W-1:0] data, input logic drop);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.command     <= cmd;
    in_ch.queue_index <= q;
    in_ch.event_data  <= data;
    in_ch.drop_full   <= drop;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    awaited.push_back(predict_outcome(cmd, q, data, drop));
    if (cmd == CMD_SEND) send_total++;
    else recv_total++;
  endtask

  task automatic receive_next();
    issue_request(CMD_RECV, QIDX_W'($urandom_range(0, NQ - 1)), rand_word(),
                  1'($urandom_range(0, 1)));
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] held;
    held = (idx == REG_ACTIVE_QUEUES) ? CFG_DW'(active_reg) : CFG_DW'(cap_reg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? value : '0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == REG_ACTIVE_QUEUES) active_reg = value[ACTQ_W-1:0];
      else cap_reg = value[CAP_W-1:0];
    end else if (prdata !== held) begin
      mismatch_count++;
      $display("%0t register %0d readback: expected %h, got %h", $time, idx, held, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned act, input int unsigned cap);
    settle();
    apb_transfer(1'b1, REG_ACTIVE_QUEUES, CFG_DW'(act));
    apb_transfer(1'b1, REG_QUEUE_CAPACITY, CFG_DW'(cap));
    apb_transfer(1'b0, REG_ACTIVE_QUEUES, '0);
    apb_transfer(1'b0, REG_QUEUE_CAPACITY, '0);
    settings_total++;
  endtask

  task automatic test_reset_state();
    apb_transfer(1'b0, REG_ACTIVE_QUEUES, '0);
    apb_transfer(1'b0, REG_QUEUE_CAPACITY, '0);
    // nothing served yet, search starts at queue 0
    receive_next();
  endtask

  task automatic test_send_receive();
    configure(4, 2);
    issue_request(CMD_SEND, 2'd0, '0, 1'b0);
    issue_request(CMD_SEND, 2'd0, '1, 1'b1);
    issue_request(CMD_SEND, 2'd0, 64'h0123_4567_89ab_cdef, 1'b1);
    issue_request(CMD_SEND, 2'd0, 64'hfedc_ba98_7654_3210, 1'b0);
    issue_request(CMD_SEND, 2'd1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    issue_request(CMD_SEND, 2'd3, 64'h5555_5555_5555_5555, 1'b1);
    repeat (5) receive_next();
  endtask

  task automatic test_service_beyond_active();
    configure(4, 16);
    issue_request(CMD_SEND, 2'd3, rand_word(), 1'b0);
    receive_next();
    issue_request(CMD_SEND, 2'd0, rand_word(), 1'b0);
    issue_request(CMD_SEND, 2'd1, rand_word(), 1'b0);
    issue_request(CMD_SEND, 2'd3, rand_word(), 1'b0);
    // last served queue now lies beyond the connected range
    configure(2, 16);
    repeat (3) receive_next();
    issue_request(CMD_SEND, 2'd2, rand_word(), 1'b1);
    issue_request(CMD_SEND, 2'd3, rand_word(), 1'b0);
    // reconnected queue still holds its event
    configure(4, 16);
    receive_next();
  endtask

  task automatic test_capacity_limits();
    configure(4, 4);
    issue_request(CMD_SEND, 2'd0, rand_word(), 1'b0);
    issue_request(CMD_SEND, 2'd0, rand_word(), 1'b0);
    // capacity below current fill
    configure(4, 1);
    issue_request(CMD_SEND, 2'd0, rand_word(), 1'b1);
    // zero capacity clamps to one
    configure(4, 0);
    issue_request(CMD_SEND, 2'd1, rand_word(), 1'b0);
    issue_request(CMD_SEND, 2'd1, rand_word(), 1'b0);
    configure(0, 0);
    receive_next();
    configure(7, 31);
    receive_next();
  endtask

  task automatic test_random_traffic();
    int unsigned act;
    int unsigned cap;
    int unsigned send_pct;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          act = 1;
          cap = 1;
        end
        1: begin
          act = 4;
          cap = 16;
        end
        2: begin
          act = 0;
          cap = 0;
        end
        3: begin
          act = 7;
          cap = 31;
        end
        default: begin
          act = $urandom_range(0, 7);
          cap = $urandom_range(0, 31);
        end
      endcase
      configure(act, cap);
      gaps_on = (phase % 3) != 2;
      send_pct = 35 + 15 * (phase % 4);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < send_pct) begin
          issue_request(CMD_SEND, QIDX_W'($urandom_range(0, NQ - 1)), rand_word(),
                        1'($urandom_range(0, 1)));
        end else begin
          receive_next();
        end
      end
    end
  endtask

  task automatic test_backpressure();
    configure(4, 16);
    gaps_on = 1'b0;
    // receiver holds off after the first result while requests keep coming
    hold_cycles = HOLD_LEN;
    repeat (BURST_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        issue_request(CMD_SEND, QIDX_W'($urandom_range(0, NQ - 1)), rand_word(),
                      1'($urandom_range(0, 1)));
      end else begin
        receive_next();
      end
    end
    // sender waits for every result before the next burst
    settle();
    gaps_on = 1'b1;
    repeat (BURST_ITEMS) begin
      if ($urandom_range(0, 99) < 40) begin
        issue_request(CMD_SEND, QIDX_W'($urandom_range(0, NQ - 1)), rand_word(),
                      1'($urandom_range(0, 1)));
      end else begin
        receive_next();
      end
    end
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: status %0d event %h queue %0d", $time,
                 out_ch.status, out_ch.event_out, out_ch.source_queue);
      end else begin
        oldest = awaited.pop_front();
        if (out_ch.status !== oldest.status || out_ch.event_out !== oldest.event_word ||
            out_ch.source_queue !== oldest.src_queue) begin
          mismatch_count++;
          $display("%0t mismatch: expected st %0d ev %h q %0d, got st %0d ev %h q %0d",
                   $time, oldest.status, oldest.event_word, oldest.src_queue,
                   out_ch.status, out_ch.event_out, out_ch.source_queue);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || psel === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("%0t no request or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_SEND;
    in_ch.queue_index <= '0;
    in_ch.event_data  <= '0;
    in_ch.drop_full   <= 1'b0;
    out_ch.ready      <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    rst_n             <= 1'b0;
    for (int i = 0; i < NQ; i++) begin
      head_ptr[i] = 0;
      fill[i] = 0;
    end
    last_queue = 0;
    served_any = 1'b0;
    active_reg = ACTQ_RESET;
    cap_reg = CAP_RESET;
    mismatch_count = 0;
    for (int s = 0; s < 4; s++) status_tally[s] = 0;
    send_total = 0;
    recv_total = 0;
    settings_total = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_send_receive();
    test_service_beyond_active();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    settle();

    $display("covered %0d sends and %0d receives under %0d register settings",
             send_total, recv_total, settings_total);
    $display("results: %0d done, %0d dropped, %0d refused, %0d found all queues empty",
             status_tally[ST_DONE], status_tally[ST_DROPPED], status_tally[ST_REFUSED],
             status_tally[ST_EMPTY]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
